// ----- hdl/delimited_frame_extractor_top_assert.svh -----
// Assertion macros for the delimited frame extractor checker.
`ifndef DELIMITED_FRAME_EXTRACTOR_TOP_ASSERT_SVH
`define DELIMITED_FRAME_EXTRACTOR_TOP_ASSERT_SVH

// Checked property, masked while reset is asserted.
`define DFE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dfe check failed");

// Checked property, also evaluated while reset is asserted.
`define DFE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dfe reset check failed");

`endif

// ----- hdl/dfe_pkg.sv -----
// Shared types and constants for the delimited frame extractor.
`default_nettype none

package dfe_pkg;

    localparam int CFG_W               = 12;
    localparam int DEFAULT_LENGTH_BITS = 12;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd255;

    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_START = 8'h53;  // 'S'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_END   = 8'h45;  // 'E'

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_END      = 2'd1,
        KIND_ABORT    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// ----- hdl/delimited_frame_extractor_top.sv -----
// Top level of the delimited frame extractor: byte history, frame tracking, result register.
`default_nettype none

// Delimited frame extractor. Accepts one received byte per transfer on the
// in_* channel and produces at most one result per byte on the out_* channel.
// "<S>" opens a frame (a frame already open is reported as aborted first),
// "<E>" closes an open frame, and payload bytes are released two bytes late so
// the delimiter bytes never appear on the output. A frame that would exceed
// max_len_reg (written through cfg_write_en / cfg_write_data, reset 255)
// ends with an overflow result. Rate: one byte per clock while the output is
// not stalled. The delimiter compare, limit check and counter increment all sit
// in one short combinational path from the history registers to the result
// register, so a result is registered in the cycle after its byte transfers.
// in_ready stays high while the result register is empty or being drained in the
// same cycle; a stalled output blocks input only once the result register is full.
module delimited_frame_extractor_top
    import dfe_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_W-1:0]       cfg_write_data,
    // byte input
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    // results
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  result_kind,
    output logic [7:0]                  payload_byte,
    output logic [LENGTH_BITS-1:0]      frame_length
);

    // Limit compare runs at the wider of the register and the counter.
    localparam int CMP_W = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

    // history and frame state
    logic [7:0]             prev_reg, prev_prev_reg;
    logic                   in_frame_reg, in_frame_next;
    logic [1:0]             held_reg, held_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [CFG_W-1:0]       max_len_reg;

    // result register
    logic                   out_valid_reg;
    kind_t                  kind_reg;
    logic [7:0]             byte_reg;
    logic [LENGTH_BITS-1:0] len_reg;

    // result of the byte being transferred
    logic                   res_valid;
    kind_t                  res_kind;
    logic [7:0]             res_byte;
    logic [LENGTH_BITS-1:0] res_len;

    logic                   accept;
    logic                   open_seen, end_seen;
    logic [CMP_W-1:0]       cfg_ext, mask_ext, limit;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign open_seen = (prev_prev_reg == CH_OPEN) && (prev_reg == CH_START)
                       && (rx_byte == CH_CLOSE);
    assign end_seen  = (prev_prev_reg == CH_OPEN) && (prev_reg == CH_END)
                       && (rx_byte == CH_CLOSE);

    // Effective limit: the smaller of the register and the counter's full scale.
    assign cfg_ext  = CMP_W'(max_len_reg);
    assign mask_ext = CMP_W'({LENGTH_BITS{1'b1}});
    assign limit    = (cfg_ext < mask_ext) ? cfg_ext : mask_ext;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        held_next     = held_reg;
        count_next    = count_reg;
        res_valid     = 1'b0;
        res_kind      = KIND_PAYLOAD;
        res_byte      = 8'd0;
        res_len       = count_reg;

        priority if (open_seen)
        begin
            // restart: report the open frame as aborted, then reopen
            res_valid     = in_frame_reg;
            res_kind      = KIND_ABORT;
            in_frame_next = 1'b1;
            held_next     = 2'd0;
            count_next    = '0;
        end
        else if (in_frame_reg && end_seen)
        begin
            res_valid     = 1'b1;
            res_kind      = KIND_END;
            in_frame_next = 1'b0;
            held_next     = 2'd0;
            count_next    = '0;
        end
        else if (in_frame_reg)
        begin
            if (held_reg >= 2'd2)
            begin
                res_valid = 1'b1;
                if (CMP_W'(count_reg) >= limit)
                begin
                    res_kind      = KIND_OVERFLOW;
                    in_frame_next = 1'b0;
                    held_next     = 2'd0;
                    count_next    = '0;
                end
                else
                begin
                    count_next = LENGTH_BITS'(count_reg + 1'b1);
                    res_kind   = KIND_PAYLOAD;
                    res_byte   = prev_prev_reg;
                    res_len    = count_next;
                end
            end
            else
            begin
                held_next = held_reg + 2'd1;
            end
        end
        else
        begin
            // outside a frame bytes only shift through the history
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= 8'd0;
            prev_prev_reg <= 8'd0;
            in_frame_reg  <= 1'b0;
            held_reg      <= 2'd0;
            count_reg     <= '0;
            max_len_reg   <= MAX_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_len_reg <= cfg_write_data;
            end
            if (accept)
            begin
                prev_prev_reg <= prev_reg;
                prev_reg      <= rx_byte;
                in_frame_reg  <= in_frame_next;
                held_reg      <= held_next;
                count_reg     <= count_next;
                out_valid_reg <= res_valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload side of the result register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg <= res_kind;
            byte_reg <= res_byte;
            len_reg  <= res_len;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign payload_byte = byte_reg;
    assign frame_length = len_reg;

endmodule

`default_nettype wire

// ----- hdl/dfe_checker.sv -----
// Port-level checker for the delimited frame extractor, with its bind.
`default_nettype none

`include "delimited_frame_extractor_top_assert.svh"

module dfe_checker
    import dfe_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [1:0]             result_kind,
    input wire logic [7:0]             payload_byte,
    input wire logic [LENGTH_BITS-1:0] frame_length
);

    // all result fields side by side, for the hold check
    logic [LENGTH_BITS+9:0] result_bits;

    assign result_bits = {result_kind, payload_byte, frame_length};

    // no result is pending while reset holds
    `DFE_ASSERT_RST(a_reset_empty, !rst_n |-> !out_valid)

    // an empty result register never blocks input
    `DFE_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)

    // only payload results carry a byte
    `DFE_ASSERT(a_byte_zero, (out_valid && result_kind != KIND_PAYLOAD) |-> payload_byte == 8'd0)

    // a payload byte is always counted in its frame
    `DFE_ASSERT(a_payload_counted, (out_valid && result_kind == KIND_PAYLOAD) |-> frame_length != '0)

    // a stalled result holds
    `DFE_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(result_bits)))

endmodule

bind delimited_frame_extractor_top dfe_checker #(.LENGTH_BITS(LENGTH_BITS)) u_dfe_checker (.*);

`default_nettype wire
